### hdl/gr6dec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gr6dec_pkg - shared definitions for the graph6 cubic graph decoder
// Limits, character codes, status codes and the stage operation record.
// ----------------------------------------------------------------------------
package gr6dec_pkg;

  // Limits of the decoder
  localparam int MAX_VERTICES = 62;
  localparam int MAX_EDGES    = 64;

  // Character coding of graph6
  localparam int HDR_OFFSET = 63;
  localparam int DATA_MAX   = 126;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_GT    = 8'h3E;

  // Field and storage widths
  localparam int VTX_W       = 6;
  localparam int DEG_W       = 3;
  localparam int DEG_SAT     = 4;
  localparam int PAIR_W      = 11;
  localparam int EDGE_W      = 7;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  // Record status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_TOO_MANY   = 3'd2,
    ST_TRUNCATED  = 3'd3,
    ST_INVALID    = 3'd4,
    ST_EDGE_LIMIT = 3'd5,
    ST_NOT_CUBIC  = 3'd6
  } status_t;

  // One operation passed from the walk sequencer to the degree stage
  typedef struct packed {
    logic              clr;      // header seen: clear the degree tables
    logic              is_edge;  // edge item, degrees to be bumped
    logic              stat;     // record status item
    logic [VTX_W-1:0]  row;
    logic [VTX_W-1:0]  col;
    logic [VTX_W-1:0]  num;
    status_t           st;       // status before the cubic test
    logic              chk;      // cubic test applies
    logic [VTX_W-1:0]  vt;
    logic [EDGE_W-1:0] et;
    logic              last;     // last item caused by the byte
  } op_t;

endpackage

### hdl/gr6dec_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gr6dec_ram - generic single-port-write RAM with registered read
// One write and one read per cycle; a read of the entry being written
// returns the old contents. The read register holds while re is low.
// ----------------------------------------------------------------------------
module gr6dec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/graph6_cubic_graph_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph6_cubic_graph_decoder_top - graph6 record decoder with cubic check
// Decodes one graph6 record per run of bytes into edge items and one
// status item per record.
// ----------------------------------------------------------------------------
// A data byte that lies inside the adjacency walk takes one step per adjacency
// bit, whether or not the bit is set, until its six bits or the walk run out;
// when such a byte ends the record and its last step emitted an edge, one more
// step carries the status item. A header byte, a byte past the end of the walk
// and a byte after an error take one step. The bit-serial walk does at most one
// read-modify-write of the vertex degree memories per cycle unless stalled.
// A byte's items pass through the degree stage and output registers; the next
// byte is accepted in the cycle in which the current one takes its last step.
// Degrees live in two 64-entry memories (degree gained as a column endpoint
// and as a row endpoint) with valid bits, so a header clears them at once.
// ----------------------------------------------------------------------------
module graph6_cubic_graph_decoder_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input bytes
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [gr6dec_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                               in_tlast,   // record_end
  // Result items
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [5:0] lower_vertex, [11:6] upper_vertex, [17:12] edge_number,
  // [20:18] status, [26:21] vertex_total, [33:27] edge_total, [39:34] zero
  output logic [gr6dec_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                               out_tuser,  // kind
  output logic                               out_tlast   // run_end
);

  import gr6dec_pkg::*;

  localparam int DEPTH = 2 ** VTX_W;
  localparam logic [7:0]        HDR_MIN8   = 8'(HDR_OFFSET);
  localparam logic [7:0]        HDR_MAX8   = 8'(HDR_OFFSET + MAX_VERTICES);
  localparam logic [7:0]        DATA_MAX8  = 8'(DATA_MAX);
  localparam logic [EDGE_W-1:0] EDGE_LIM   = EDGE_W'(MAX_EDGES);
  localparam logic [DEG_W-1:0]  DSAT       = DEG_W'(DEG_SAT);
  localparam logic [2:0]        LAST_BIT   = 3'd5;

  // --------------------------------------------------------------------------
  // Walk sequencer state
  // --------------------------------------------------------------------------
  logic              hdr_pend_r, hdr_pend_nxt;
  logic [VTX_W-1:0]  vcnt_r, vcnt_nxt;
  logic [VTX_W-1:0]  row_r, row_nxt;
  logic [VTX_W-1:0]  col_r, col_nxt;
  logic [PAIR_W-1:0] pleft_r, pleft_nxt;
  logic [EDGE_W-1:0] edges_r, edges_nxt;
  status_t           err_r, err_nxt;
  logic              busy_r;
  logic [7:0]        byte_r;
  logic              end_r;
  logic [2:0]        bitpos_r, bitpos_nxt;
  logic              sphase_r, sphase_nxt;

  logic              adv;
  logic              step;
  logic              in_acc;
  logic              finish;
  logic              bits_done;
  logic              emit;
  op_t               op;
  logic              op_vld;
  logic [5:0]        vbits;
  logic [2:0]        idx;
  logic [PAIR_W-1:0] pl_after;
  logic [2:0]        look_k;
  logic              later_any;
  logic              edge_last;

  // Degree stage state
  logic              s1_vld_r;
  op_t               s1_op_r;
  logic [DEPTH-1:0]  val_a_r;
  logic [DEPTH-1:0]  val_b_r;
  logic              byp_vld_r;
  logic [VTX_W-1:0]  byp_a_addr_r;
  logic [DEG_W-1:0]  byp_a_data_r;
  logic [VTX_W-1:0]  byp_b_addr_r;
  logic [DEG_W-1:0]  byp_b_data_r;
  logic              col_any_r;
  logic [VTX_W-1:0]  col_cur_r;
  logic [DEG_W-1:0]  col_deg_r;
  logic [EDGE_W-1:0] cnt_r, cnt_nxt;

  logic              commit;
  logic              ram_re;
  logic              ram_we;
  logic [DEG_W-1:0]  rd_a;
  logic [DEG_W-1:0]  rd_b;
  logic [DEG_W-1:0]  a_val;
  logic [DEG_W-1:0]  b_val;
  logic [3:0]        deg_sum;
  logic [DEG_W-1:0]  deg_r;
  logic [DEG_W-1:0]  b_new;
  logic [DEG_W-1:0]  dc;
  logic [DEG_W-1:0]  dc_new;
  logic [EDGE_W-1:0] cnt_eff;
  status_t           st_final;

  // Output register
  logic                   out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_kind_r;
  logic                   out_last_r;

  // --------------------------------------------------------------------------
  // Handshake and pipeline advance
  // --------------------------------------------------------------------------
  assign adv       = !out_vld_r || out_tready;
  assign step      = busy_r && adv;
  assign in_tready = !busy_r || (adv && finish);
  assign in_acc    = in_tvalid && in_tready;
  assign commit    = adv && s1_vld_r;

  assign vbits    = 6'(byte_r - HDR_MIN8);
  assign idx      = LAST_BIT - bitpos_r;
  assign pl_after = pleft_r - PAIR_W'(1);

  // Look ahead over the bits of this byte still inside the walk, so that an
  // edge knows whether it is the last item of the byte.
  always_comb begin
    look_k    = (pl_after >= PAIR_W'(idx)) ? idx : pl_after[2:0];
    later_any = 1'b0;
    for (int j = 0; j < 6; j++) begin
      if ((3'(j) < idx) && (({1'b0, 3'(j)} + {1'b0, look_k}) >= {1'b0, idx}) &&
          vbits[j]) begin
        later_any = 1'b1;
      end
    end
    edge_last = !end_r && !(later_any && ((edges_r + EDGE_W'(1)) < EDGE_LIM));
  end

  // --------------------------------------------------------------------------
  // Walk sequencer: unless stalled, one header, one adjacency bit or one status per cycle
  // --------------------------------------------------------------------------
  always_comb begin
    hdr_pend_nxt = hdr_pend_r;
    vcnt_nxt     = vcnt_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    pleft_nxt    = pleft_r;
    edges_nxt    = edges_r;
    err_nxt      = err_r;
    bitpos_nxt   = bitpos_r;
    sphase_nxt   = sphase_r;
    op           = '0;
    op_vld       = 1'b0;
    finish       = 1'b0;
    bits_done    = 1'b0;
    emit         = 1'b0;

    if (sphase_r) begin
      // Status item left over after an edge in the last step
      op_vld       = 1'b1;
      op.stat      = 1'b1;
      finish       = 1'b1;
      sphase_nxt   = 1'b0;
      hdr_pend_nxt = 1'b1;
    end else if (hdr_pend_r) begin
      // Header byte restarts the record
      row_nxt   = '0;
      col_nxt   = VTX_W'(1);
      edges_nxt = '0;
      err_nxt   = ST_OK;
      vcnt_nxt  = '0;
      if (byte_r == CHAR_COLON || byte_r == CHAR_GT) begin
        err_nxt = ST_BAD_HEADER;
      end else if (byte_r < HDR_MIN8 || byte_r > HDR_MAX8) begin
        err_nxt = ST_TOO_MANY;
      end else begin
        vcnt_nxt = VTX_W'(byte_r - HDR_MIN8);
      end
      pleft_nxt    = PAIR_W'(((2 * VTX_W)'(vcnt_nxt) *
                              (2 * VTX_W)'(vcnt_nxt - VTX_W'(1))) >> 1);
      hdr_pend_nxt = 1'b0;
      op_vld       = 1'b1;
      op.clr       = 1'b1;
      bits_done    = 1'b1;
    end else begin
      // Data byte
      if (err_r != ST_OK || pleft_r == '0) begin
        bits_done = 1'b1;
      end else if (bitpos_r == '0 && (byte_r < HDR_MIN8 || byte_r > DATA_MAX8)) begin
        err_nxt   = ST_INVALID;
        bits_done = 1'b1;
      end else begin
        if (vbits[idx]) begin
          if (edges_r >= EDGE_LIM) begin
            err_nxt   = ST_EDGE_LIMIT;
            bits_done = 1'b1;
          end else begin
            emit       = 1'b1;
            op_vld     = 1'b1;
            op.is_edge = 1'b1;
            op.row     = row_r;
            op.col     = col_r;
            op.num     = edges_r[VTX_W-1:0];
            edges_nxt  = edges_r + EDGE_W'(1);
          end
        end
        if (err_nxt == ST_OK) begin
          pleft_nxt = pleft_r - PAIR_W'(1);
          if ((row_r + VTX_W'(1)) == col_r) begin
            row_nxt = '0;
            col_nxt = col_r + VTX_W'(1);
          end else begin
            row_nxt = row_r + VTX_W'(1);
          end
          bitpos_nxt = bitpos_r + 3'd1;
          bits_done  = (bitpos_r == LAST_BIT) || (pleft_r == PAIR_W'(1));
        end
      end
    end

    // End of the byte's bits: status now, status in a further step, or done
    if (!sphase_r && bits_done) begin
      if (end_r) begin
        if (emit) begin
          sphase_nxt = 1'b1;
        end else begin
          op_vld       = 1'b1;
          op.stat      = 1'b1;
          finish       = 1'b1;
          hdr_pend_nxt = 1'b1;
        end
      end else begin
        finish = 1'b1;
      end
    end

    // Status fields from the state as it stands after this step
    op.st   = (err_nxt != ST_OK) ? err_nxt :
              ((pleft_nxt != '0) ? ST_TRUNCATED : ST_OK);
    op.chk  = (err_nxt == ST_OK) && (pleft_nxt == '0);
    op.vt   = vcnt_nxt;
    op.et   = edges_nxt;
    op.last = op.is_edge ? edge_last : 1'b1;
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pend_r <= 1'b1;
      vcnt_r     <= '0;
      row_r      <= '0;
      col_r      <= VTX_W'(1);
      pleft_r    <= '0;
      edges_r    <= '0;
      err_r      <= ST_OK;
      busy_r     <= 1'b0;
      bitpos_r   <= '0;
      sphase_r   <= 1'b0;
    end else begin
      if (step) begin
        hdr_pend_r <= hdr_pend_nxt;
        vcnt_r     <= vcnt_nxt;
        row_r      <= row_nxt;
        col_r      <= col_nxt;
        pleft_r    <= pleft_nxt;
        edges_r    <= edges_nxt;
        err_r      <= err_nxt;
        bitpos_r   <= bitpos_nxt;
        sphase_r   <= sphase_nxt;
      end
      if (in_acc) begin
        busy_r   <= 1'b1;
        bitpos_r <= '0;
        sphase_r <= 1'b0;
      end else if (step && finish) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Byte register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_tdata;
      end_r  <= in_tlast;
    end
  end

  // --------------------------------------------------------------------------
  // Degree memories: column-phase degree (a) and row-phase degree (b)
  // --------------------------------------------------------------------------
  assign ram_re = step && op_vld && op.is_edge;
  assign ram_we = commit && s1_op_r.is_edge;

  gr6dec_ram #(.WIDTH(DEG_W), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_op_r.col),
    .wdata (dc_new),
    .re    (ram_re),
    .raddr (row_r),
    .rdata (rd_a)
  );

  gr6dec_ram #(.WIDTH(DEG_W), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_op_r.row),
    .wdata (b_new),
    .re    (ram_re),
    .raddr (row_r),
    .rdata (rd_b)
  );

  // Row degree with forwarding of the write made in the read cycle
  always_comb begin
    if (byp_vld_r && byp_a_addr_r == s1_op_r.row) begin
      a_val = byp_a_data_r;
    end else begin
      a_val = val_a_r[s1_op_r.row] ? rd_a : '0;
    end
    if (byp_vld_r && byp_b_addr_r == s1_op_r.row) begin
      b_val = byp_b_data_r;
    end else begin
      b_val = val_b_r[s1_op_r.row] ? rd_b : '0;
    end
    deg_sum = {1'b0, a_val} + {1'b0, b_val};
    deg_r   = (deg_sum >= 4'(DEG_SAT)) ? DSAT : deg_sum[DEG_W-1:0];
    b_new   = (deg_r < DSAT) ? (b_val + DEG_W'(1)) : b_val;

    // A column vertex has no degree before its own column starts
    dc     = (col_any_r && col_cur_r == s1_op_r.col) ? col_deg_r : '0;
    dc_new = (dc < DSAT) ? (dc + DEG_W'(1)) : dc;

    cnt_nxt = cnt_r;
    if (deg_r == DEG_W'(2)) begin
      cnt_nxt = cnt_nxt + EDGE_W'(1);
    end else if (deg_r == DEG_W'(3)) begin
      cnt_nxt = cnt_nxt - EDGE_W'(1);
    end
    if (dc == DEG_W'(2)) begin
      cnt_nxt = cnt_nxt + EDGE_W'(1);
    end else if (dc == DEG_W'(3)) begin
      cnt_nxt = cnt_nxt - EDGE_W'(1);
    end

    // Final status with the cubic test
    cnt_eff  = s1_op_r.clr ? '0 : cnt_r;
    st_final = (s1_op_r.chk && cnt_eff != EDGE_W'(s1_op_r.vt)) ? ST_NOT_CUBIC :
               s1_op_r.st;
  end

  // Degree stage control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      val_a_r   <= '0;
      val_b_r   <= '0;
      byp_vld_r <= 1'b0;
      col_any_r <= 1'b0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= step && op_vld;
      out_vld_r <= s1_vld_r && (s1_op_r.is_edge || s1_op_r.stat);
      if (s1_vld_r) begin
        byp_vld_r <= s1_op_r.is_edge;
        if (s1_op_r.clr) begin
          val_a_r   <= '0;
          val_b_r   <= '0;
          col_any_r <= 1'b0;
          cnt_r     <= '0;
        end else if (s1_op_r.is_edge) begin
          val_a_r[s1_op_r.col] <= 1'b1;
          val_b_r[s1_op_r.row] <= 1'b1;
          col_any_r            <= 1'b1;
          cnt_r                <= cnt_nxt;
        end
      end
    end
  end

  // Degree stage and output payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r <= op;
      if (commit && s1_op_r.is_edge) begin
        byp_a_addr_r <= s1_op_r.col;
        byp_a_data_r <= dc_new;
        byp_b_addr_r <= s1_op_r.row;
        byp_b_data_r <= b_new;
        col_cur_r    <= s1_op_r.col;
        col_deg_r    <= dc_new;
      end
      if (s1_op_r.is_edge) begin
        out_data_r <= {6'b0, EDGE_W'(0), VTX_W'(0), ST_OK,
                       s1_op_r.num, s1_op_r.col, s1_op_r.row};
        out_kind_r <= 1'b0;
        out_last_r <= s1_op_r.last;
      end else begin
        out_data_r <= {6'b0, s1_op_r.et, s1_op_r.vt, st_final,
                       VTX_W'(0), VTX_W'(0), VTX_W'(0)};
        out_kind_r <= 1'b1;
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= EDGE_W'(MAX_VERTICES))
    else $error("degree-3 vertex count above the vertex limit");

  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    (pleft_r != '0) |-> (row_r < col_r))
    else $error("pair walk left the upper triangle");

  a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edges_r <= EDGE_LIM)
    else $error("edge count above the edge limit");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("status item not marked as last of its byte");

endmodule
